FILE: src/rcmix_pkg.sv
// ----------------------------------------------------------------------------
// rcmix_pkg
// Shared types, register map and constants for the skid-steer mixer.
// ----------------------------------------------------------------------------
package rcmix_pkg;

  localparam int PULSE_W   = 16;
  localparam int REG_W     = 12;
  localparam int BAND_W    = 8;
  localparam int LEVEL_W   = 13;
  localparam int CFG_W     = 13;
  localparam int POINT_W   = 13;
  localparam int DIV_W     = 20;
  localparam int DIV_STEPS = DIV_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int MAP_LIM  = 127;
  localparam int MAP_SPAN = 2 * MAP_LIM;

  typedef enum logic [2:0] {
    REG_PULSE_MIN      = 3'd0,
    REG_PULSE_MAX      = 3'd1,
    REG_PULSE_NEUTRAL  = 3'd2,
    REG_DEAD_BAND      = 3'd3,
    REG_SLEW_LIMIT     = 3'd4,
    REG_PWM_TOP        = 3'd5,
    REG_FULL_THRESHOLD = 3'd6,
    REG_FULL_LEVEL     = 3'd7
  } reg_index_t;

  localparam logic [REG_W-1:0]   RST_PULSE_MIN      = 12'd1100;
  localparam logic [REG_W-1:0]   RST_PULSE_MAX      = 12'd1900;
  localparam logic [REG_W-1:0]   RST_PULSE_NEUTRAL  = 12'd1500;
  localparam logic [BAND_W-1:0]  RST_DEAD_BAND      = 8'd20;
  localparam logic [REG_W-1:0]   RST_SLEW_LIMIT     = 12'd50;
  localparam logic [REG_W-1:0]   RST_PWM_TOP        = 12'd1249;
  localparam logic [REG_W-1:0]   RST_FULL_THRESHOLD = 12'd1240;
  localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL     = 13'd1250;

  typedef struct packed {
    logic [REG_W-1:0]   pulse_min;
    logic [REG_W-1:0]   pulse_max;
    logic [REG_W-1:0]   pulse_neutral;
    logic [BAND_W-1:0]  dead_band;
    logic [REG_W-1:0]   slew_limit;
    logic [REG_W-1:0]   pwm_top;
    logic [REG_W-1:0]   full_threshold;
    logic [LEVEL_W-1:0] full_level;
  } cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] throttle_pulse;
    logic [PULSE_W-1:0] steer_pulse;
  } in_item_t;

  typedef struct packed {
    logic               left_dir;
    logic [LEVEL_W-1:0] left_level;
    logic               right_dir;
    logic [LEVEL_W-1:0] right_level;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [REG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/rcmix_div.sv
// ----------------------------------------------------------------------------
// rcmix_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcmix_div (
  input  logic              clk,
  input  logic              rst,
  input  rcmix_pkg::div_req_t req,
  output rcmix_pkg::div_rsp_t rsp
);
  import rcmix_pkg::*;

  logic [DIV_W-1:0]     quo;
  logic [REG_W-1:0]     rem;
  logic [REG_W-1:0]     den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [REG_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && cnt == '0) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && cnt == '0) begin
      quo <= req.dividend;
      rem <= '0;
      den <= req.divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? REG_W'(trial - {1'b0, den}) : trial[REG_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: src/rcmix_core.sv
// ----------------------------------------------------------------------------
// rcmix_core
// Sequencer and datapath: pulse shaping, mixing, scaling and slew, using
// one shared multiplier and the shared divider.
// ----------------------------------------------------------------------------
module rcmix_core (
  input  logic                 clk,
  input  logic                 rst,
  input  rcmix_pkg::cfg_t      cfg,
  input  logic                 start,
  input  rcmix_pkg::in_item_t  item,
  output logic                 idle,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rcmix_pkg::out_item_t res
);
  import rcmix_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_THR_CLAMP = 16'h0002,
    S_THR_START = 16'h0004,
    S_THR_WAIT  = 16'h0008,
    S_STR_CLAMP = 16'h0010,
    S_STR_START = 16'h0020,
    S_STR_WAIT  = 16'h0040,
    S_PROP_START= 16'h0080,
    S_PROP_WAIT = 16'h0100,
    S_MIX       = 16'h0200,
    S_LT_START  = 16'h0400,
    S_LT_WAIT   = 16'h0800,
    S_RT_START  = 16'h1000,
    S_RT_WAIT   = 16'h2000,
    S_SLEW      = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state, state_next;

  logic [PULSE_W-1:0]        thr_raw, str_raw;
  logic [REG_W-1:0]          xv;
  logic signed [7:0]         thr, str, prop;
  logic                      neg;
  logic [7:0]                ls, rs;
  logic                      ld, rd;
  logic signed [13:0]        lt, rt;
  logic signed [POINT_W-1:0] left_point, right_point;

  logic [PULSE_W-1:0]        raw_sel;
  logic [REG_W-1:0]          x_clamp, x_shaped;
  logic signed [REG_W:0]     dz_diff;
  logic [REG_W-1:0]          dz_mag;
  logic                      map_empty;
  logic signed [12:0]        mul_a, mul_b;
  logic signed [25:0]        prod;
  logic [25:0]               prod_mag;
  logic [REG_W-1:0]          den_sel;
  logic signed [21:0]        qs;
  logic signed [21:0]        map_v;
  logic signed [7:0]         map_sat;
  logic signed [9:0]         prop_v;
  logic [7:0]                outer;
  logic signed [8:0]         inner_s;
  logic [7:0]                inner;
  logic                      inner_dir;
  div_req_t                  dreq;
  div_rsp_t                  drsp;

  function automatic logic signed [POINT_W-1:0] slew_step(
    input logic signed [POINT_W-1:0] point,
    input logic signed [13:0]        target,
    input logic [REG_W-1:0]          lim
  );
    logic signed [14:0] err;
    logic signed [14:0] lim_s;
    err   = 15'(target) - 15'(point);
    lim_s = signed'({3'b000, lim});
    if (err > lim_s) err = lim_s;
    if (err < -lim_s) err = -lim_s;
    return POINT_W'(point + err[POINT_W-1:0]);
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of(
    input logic signed [POINT_W-1:0] point,
    input logic [REG_W-1:0]          thresh,
    input logic [LEVEL_W-1:0]        full
  );
    logic [LEVEL_W-1:0] mag;
    mag = point[POINT_W-1] ? LEVEL_W'(-point) : LEVEL_W'(point);
    return (mag > {1'b0, thresh}) ? full : mag;
  endfunction

  rcmix_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // pulse clamp and dead band
  always_comb begin
    raw_sel = (state == S_THR_CLAMP) ? thr_raw : str_raw;
    if (raw_sel < PULSE_W'(cfg.pulse_min)) begin
      x_clamp = cfg.pulse_min;
    end else if (raw_sel > PULSE_W'(cfg.pulse_max)) begin
      x_clamp = cfg.pulse_max;
    end else begin
      x_clamp = raw_sel[REG_W-1:0];
    end
    dz_diff  = signed'({1'b0, x_clamp}) - signed'({1'b0, cfg.pulse_neutral});
    dz_mag   = dz_diff[REG_W] ? REG_W'(-dz_diff) : dz_diff[REG_W-1:0];
    x_shaped = (dz_mag <= REG_W'(cfg.dead_band)) ? cfg.pulse_neutral : x_clamp;
  end

  assign map_empty = cfg.pulse_max <= cfg.pulse_min;

  // shared multiplier operand select
  always_comb begin
    mul_a   = signed'({1'b0, xv}) - signed'({1'b0, cfg.pulse_min});
    mul_b   = 13'(MAP_SPAN);
    den_sel = cfg.pulse_max - cfg.pulse_min;
    case (state)
      S_PROP_START: begin
        mul_a   = 13'(str) + 13'(MAP_LIM);
        mul_b   = 13'(thr) <<< 1;
        den_sel = REG_W'(MAP_SPAN);
      end
      S_LT_START: begin
        mul_a   = signed'({5'b0, ls});
        mul_b   = signed'({1'b0, cfg.pwm_top});
        den_sel = REG_W'(MAP_LIM);
      end
      S_RT_START: begin
        mul_a   = signed'({5'b0, rs});
        mul_b   = signed'({1'b0, cfg.pwm_top});
        den_sel = REG_W'(MAP_LIM);
      end
      default: begin
      end
    endcase
    prod     = mul_a * mul_b;
    prod_mag = prod[25] ? 26'(-prod) : 26'(prod);
  end

  always_comb begin
    dreq.dividend = prod_mag[DIV_W-1:0];
    dreq.divisor  = den_sel;
    dreq.start    = ((state == S_THR_START || state == S_STR_START) && !map_empty) ||
                    state == S_PROP_START || state == S_LT_START || state == S_RT_START;
  end

  // signed quotient, truncated toward zero
  always_comb begin
    qs     = neg ? -signed'({2'b00, drsp.quotient}) : signed'({2'b00, drsp.quotient});
    map_v  = qs - 22'(MAP_LIM);
    if (map_v > 22'(MAP_LIM)) begin
      map_sat = 8'(MAP_LIM);
    end else if (map_v < -22'(MAP_LIM)) begin
      map_sat = -8'(MAP_LIM);
    end else begin
      map_sat = map_v[7:0];
    end
    prop_v = qs[9:0] - 10'(thr);
  end

  // mixing
  always_comb begin
    outer     = thr[7] ? 8'(-thr) : 8'(thr);
    inner_s   = signed'({1'b0, outer}) - (prop[7] ? 9'(-prop) : 9'(prop));
    inner_dir = thr[7];
    inner     = inner_s[7:0];
    if (inner_s[8]) begin
      inner_dir = !thr[7];
      inner     = 8'(-inner_s);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (start) state_next = S_THR_CLAMP;
      S_THR_CLAMP:  state_next = S_THR_START;
      S_THR_START:  state_next = map_empty ? S_STR_CLAMP : S_THR_WAIT;
      S_THR_WAIT:   if (drsp.done) state_next = S_STR_CLAMP;
      S_STR_CLAMP:  state_next = S_STR_START;
      S_STR_START:  state_next = map_empty ? S_PROP_START : S_STR_WAIT;
      S_STR_WAIT:   if (drsp.done) state_next = S_PROP_START;
      S_PROP_START: state_next = S_PROP_WAIT;
      S_PROP_WAIT:  if (drsp.done) state_next = S_MIX;
      S_MIX:        state_next = S_LT_START;
      S_LT_START:   state_next = S_LT_WAIT;
      S_LT_WAIT:    if (drsp.done) state_next = S_RT_START;
      S_RT_START:   state_next = S_RT_WAIT;
      S_RT_WAIT:    if (drsp.done) state_next = S_SLEW;
      S_SLEW:       state_next = S_DONE;
      S_DONE:       if (res_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      left_point  <= '0;
      right_point <= '0;
    end else begin
      state <= state_next;
      if (state == S_SLEW) begin
        left_point  <= slew_step(left_point, lt, cfg.slew_limit);
        right_point <= slew_step(right_point, rt, cfg.slew_limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        thr_raw <= item.throttle_pulse;
        str_raw <= item.steer_pulse;
      end
      S_THR_CLAMP, S_STR_CLAMP: xv <= x_shaped;
      S_THR_START: begin
        neg <= prod[25];
        if (map_empty) thr <= '0;
      end
      S_STR_START: begin
        neg <= prod[25];
        if (map_empty) str <= '0;
      end
      S_PROP_START, S_LT_START, S_RT_START: neg <= prod[25];
      S_THR_WAIT:  if (drsp.done) thr <= map_sat;
      S_STR_WAIT:  if (drsp.done) str <= map_sat;
      S_PROP_WAIT: if (drsp.done) prop <= prop_v[7:0];
      S_MIX: begin
        if (str[7]) begin
          ls <= inner;
          ld <= inner_dir;
          rs <= outer;
          rd <= thr[7];
        end else begin
          ls <= outer;
          ld <= thr[7];
          rs <= inner;
          rd <= inner_dir;
        end
      end
      S_LT_WAIT: if (drsp.done) lt <= ld ? qs[13:0] : -qs[13:0];
      S_RT_WAIT: if (drsp.done) rt <= rd ? qs[13:0] : -qs[13:0];
      default: begin
      end
    endcase
  end

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    res.left_dir    = !left_point[POINT_W-1];
    res.left_level  = level_of(left_point, cfg.full_threshold, cfg.full_level);
    res.right_dir   = !right_point[POINT_W-1];
    res.right_level = level_of(right_point, cfg.full_threshold, cfg.full_level);
  end

endmodule

FILE: src/rc_skid_steer_mixer_slew_top.sv
// ----------------------------------------------------------------------------
// rc_skid_steer_mixer_slew_top
// Skid-steer mixer with slew-limited track setpoints and PWM level output.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one control tick (throttle and steering pulse widths),
//   taken on in_valid && in_ready. out_item carries one result per tick
//   (direction and PWM level for each track), taken on out_valid && out_ready.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while idle, as the block does not enforce it.
// Sequencing:
//   One item at a time. Each item runs five divisions through the shared
//   20-step restoring divider; both pulse divisions are skipped when the
//   pulse range is empty. in_ready rises together with out_valid, so no new
//   item is taken until the previous result has left the core.
// Reset:
//   rst clears both setpoints to zero, loads register defaults and drops
//   out_valid.
// Stall:
//   A result held in the output register does not block the next item; a
//   second finished result waits in the core until the register frees.
// ----------------------------------------------------------------------------
module rc_skid_steer_mixer_slew_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rcmix_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rcmix_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [rcmix_pkg::CFG_W-1:0] cfg_data
);
  import rcmix_pkg::*;

  cfg_t      cfg;
  logic      core_idle;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min      <= RST_PULSE_MIN;
      cfg.pulse_max      <= RST_PULSE_MAX;
      cfg.pulse_neutral  <= RST_PULSE_NEUTRAL;
      cfg.dead_band      <= RST_DEAD_BAND;
      cfg.slew_limit     <= RST_SLEW_LIMIT;
      cfg.pwm_top        <= RST_PWM_TOP;
      cfg.full_threshold <= RST_FULL_THRESHOLD;
      cfg.full_level     <= RST_FULL_LEVEL;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PULSE_MIN:      cfg.pulse_min      <= cfg_data[REG_W-1:0];
        REG_PULSE_MAX:      cfg.pulse_max      <= cfg_data[REG_W-1:0];
        REG_PULSE_NEUTRAL:  cfg.pulse_neutral  <= cfg_data[REG_W-1:0];
        REG_DEAD_BAND:      cfg.dead_band      <= cfg_data[BAND_W-1:0];
        REG_SLEW_LIMIT:     cfg.slew_limit     <= cfg_data[REG_W-1:0];
        REG_PWM_TOP:        cfg.pwm_top        <= cfg_data[REG_W-1:0];
        REG_FULL_THRESHOLD: cfg.full_threshold <= cfg_data[REG_W-1:0];
        REG_FULL_LEVEL:     cfg.full_level     <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcmix_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid && in_ready),
    .item      (in_item),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ready  = core_idle;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

endmodule

FILE: src/rcmix_chk.sv
// ----------------------------------------------------------------------------
// rcmix_chk
// Port-level checks for the skid-steer mixer, bound to the top level.
// ----------------------------------------------------------------------------
module rcmix_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input rcmix_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_ready,
  input rcmix_pkg::out_item_t out_item,
  input logic                 cfg_we,
  input logic [2:0]           cfg_index,
  input logic [rcmix_pkg::CFG_W-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("block ready or finished right after accepting an item");

  a_result_frees_core: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while core still busy");

endmodule

bind rc_skid_steer_mixer_slew_top rcmix_chk u_rcmix_chk (.*);

FILE: bench/tb_rc_skid_steer_mixer_slew_top.sv
// ----------------------------------------------------------------------------
// tb_rc_skid_steer_mixer_slew_top
// Self-checking bench for the skid-steer mixer with slew-limited setpoints.
//
// A directed table covers reset behavior, pulse extremes, the dead band,
// full-speed level substitution, frozen setpoints, empty and inverted pulse
// ranges and saturated mapping. Random phases follow under varied register
// settings. Every accepted tick is run through a local mixer model. Each
// track command that leaves the block is compared field by field with the
// oldest prediction. Both handshakes idle at random, with one quiet stretch,
// long receiver hold-offs and a sender pause until the block drains.
// ----------------------------------------------------------------------------
module tb_rc_skid_steer_mixer_slew_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcmix_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 11;
  localparam int PHASE_ITEMS = 150;
  localparam int TAIL_CYCLES = 200;
  localparam int HOLD_CYCLES = 500;
  localparam int PRINT_CAP   = 50;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    reg_index_t         idx;
    logic [CFG_W-1:0]   data;
    logic [PULSE_W-1:0] thr;
    logic [PULSE_W-1:0] str;
    bit                 typed;
    out_item_t          want;
  } row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  cfg_t      regs_now;
  int        left_set;
  int        right_set;
  out_item_t track_cmds_due[$];
  out_item_t head;
  int        errors = 0;
  int        sent = 0;
  int        taken = 0;
  int        hold = 0;
  int        idle_cycles = 0;

  rc_skid_steer_mixer_slew_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rescale(longint x, longint a0, longint a1, longint b0, longint b1);
    if (a1 <= a0) return 0;
    return (x - a0) * (b1 - b0) / (a1 - a0) + b0;
  endfunction

  function automatic longint pulse_to_cmd(logic [PULSE_W-1:0] raw);
    longint lo, hi, ctr, band, x, v;
    lo   = longint'(regs_now.pulse_min);
    hi   = longint'(regs_now.pulse_max);
    ctr  = longint'(regs_now.pulse_neutral);
    band = longint'(regs_now.dead_band);
    x    = longint'(raw);
    if (x < lo) x = lo;
    else if (x > hi) x = hi;
    if (mag64(x - ctr) <= band) x = ctr;
    v = rescale(x, lo, hi, -MAP_LIM, MAP_LIM);
    if (v > MAP_LIM) v = MAP_LIM;
    if (v < -MAP_LIM) v = -MAP_LIM;
    return v;
  endfunction

  function automatic int step_toward(int p, longint target);
    longint err, lim;
    err = target - p;
    lim = longint'(regs_now.slew_limit);
    if (err > lim) err = lim;
    if (err < -lim) err = -lim;
    return int'(p + err);
  endfunction

  function automatic logic [LEVEL_W-1:0] level_of(int p);
    longint m;
    m = mag64(p);
    if (m > longint'(regs_now.full_threshold)) m = longint'(regs_now.full_level);
    return m[LEVEL_W-1:0];
  endfunction

  function automatic out_item_t mix_tick(in_item_t it);
    longint thr, str, prop, outer, inner, ls, rs, lt, rt, top;
    bit outer_fwd, inner_fwd, lfwd, rfwd;
    out_item_t res;
    thr = pulse_to_cmd(it.throttle_pulse);
    str = pulse_to_cmd(it.steer_pulse);
    top = longint'(regs_now.pwm_top);
    prop = rescale(str, -MAP_LIM, MAP_LIM, -thr, thr);
    outer = mag64(thr);
    outer_fwd = (thr < 0);
    inner = outer - mag64(prop);
    inner_fwd = outer_fwd;
    if (inner < 0) begin
      inner_fwd = !inner_fwd;
      inner = -inner;
    end
    if (str < 0) begin
      ls = inner; lfwd = inner_fwd; rs = outer; rfwd = outer_fwd;
    end else begin
      ls = outer; lfwd = outer_fwd; rs = inner; rfwd = inner_fwd;
    end
    lt = ls * top / MAP_LIM;
    rt = rs * top / MAP_LIM;
    if (!lfwd) lt = -lt;
    if (!rfwd) rt = -rt;
    left_set  = step_toward(left_set, lt);
    right_set = step_toward(right_set, rt);
    res.left_dir    = (left_set >= 0);
    res.left_level  = level_of(left_set);
    res.right_dir   = (right_set >= 0);
    res.right_level = level_of(right_set);
    return res;
  endfunction

  function automatic out_item_t pair_out(int ld, int ll, int rd, int rl);
    out_item_t r;
    r.left_dir    = ld[0];
    r.left_level  = ll[LEVEL_W-1:0];
    r.right_dir   = rd[0];
    r.right_level = rl[LEVEL_W-1:0];
    return r;
  endfunction

  function automatic row_t tick_row(int thr, int str);
    row_t r;
    r = '{kind: ROW_TICK, idx: REG_PULSE_MIN, data: '0, thr: thr[PULSE_W-1:0],
          str: str[PULSE_W-1:0], typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t typed_row(int thr, int str, out_item_t want);
    row_t r;
    r = tick_row(thr, str);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t write_row(reg_index_t idx, int data);
    row_t r;
    r = tick_row(0, 0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data[CFG_W-1:0];
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] pick_pulse();
    int lo, hi, ctr, band, a, b, v;
    lo   = int'(regs_now.pulse_min);
    hi   = int'(regs_now.pulse_max);
    ctr  = int'(regs_now.pulse_neutral);
    band = int'(regs_now.dead_band);
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(0, 19))
      0, 1, 2: v = int'($urandom_range(0, 65535));
      3, 4, 5: v = ctr - band - 2 + int'($urandom_range(0, 2 * band + 4));
      6:       v = lo;
      7:       v = hi;
      8:       v = ctr;
      default: v = a - 40 + int'($urandom_range(0, b - a + 80));
    endcase
    if (v < 0) v = 0;
    return v[PULSE_W-1:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (track_cmds_due.size() != 0);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PULSE_MIN:      regs_now.pulse_min      = data[REG_W-1:0];
      REG_PULSE_MAX:      regs_now.pulse_max      = data[REG_W-1:0];
      REG_PULSE_NEUTRAL:  regs_now.pulse_neutral  = data[REG_W-1:0];
      REG_DEAD_BAND:      regs_now.dead_band      = data[BAND_W-1:0];
      REG_SLEW_LIMIT:     regs_now.slew_limit     = data[REG_W-1:0];
      REG_PWM_TOP:        regs_now.pwm_top        = data[REG_W-1:0];
      REG_FULL_THRESHOLD: regs_now.full_threshold = data[REG_W-1:0];
      REG_FULL_LEVEL:     regs_now.full_level     = data[LEVEL_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_phase(input int ph);
    int vals [8];
    int lo, hi;
    settle();
    case (ph % 4)
      0: begin
        vals[REG_PULSE_MIN]      = int'(RST_PULSE_MIN);
        vals[REG_PULSE_MAX]      = int'(RST_PULSE_MAX);
        vals[REG_PULSE_NEUTRAL]  = int'(RST_PULSE_NEUTRAL);
        vals[REG_DEAD_BAND]      = int'(RST_DEAD_BAND);
        vals[REG_SLEW_LIMIT]     = int'(RST_SLEW_LIMIT);
        vals[REG_PWM_TOP]        = int'(RST_PWM_TOP);
        vals[REG_FULL_THRESHOLD] = int'(RST_FULL_THRESHOLD);
        vals[REG_FULL_LEVEL]     = int'(RST_FULL_LEVEL);
      end
      1: begin
        lo = 900 + int'($urandom_range(0, 300));
        hi = 1700 + int'($urandom_range(0, 400));
        vals[REG_PULSE_MIN]      = lo;
        vals[REG_PULSE_MAX]      = hi;
        vals[REG_PULSE_NEUTRAL]  = (lo + hi) / 2 - 40 + int'($urandom_range(0, 80));
        vals[REG_DEAD_BAND]      = int'($urandom_range(0, 60));
        vals[REG_SLEW_LIMIT]     = int'($urandom_range(1, 300));
        vals[REG_PWM_TOP]        = int'($urandom_range(200, 4095));
        vals[REG_FULL_THRESHOLD] = int'($urandom_range(0, 4095));
        vals[REG_FULL_LEVEL]     = int'($urandom_range(0, 4096));
      end
      2: begin
        foreach (vals[i]) vals[i] = int'($urandom_range(0, (1 << CFG_W) - 1));
      end
      default: begin
        if ((ph / 4) % 2 == 0) begin
          vals[REG_PULSE_MIN]      = 0;
          vals[REG_PULSE_MAX]      = 4095;
          vals[REG_PULSE_NEUTRAL]  = 2048;
          vals[REG_DEAD_BAND]      = 255;
          vals[REG_SLEW_LIMIT]     = 4095;
          vals[REG_PWM_TOP]        = 4095;
          vals[REG_FULL_THRESHOLD] = 4095;
          vals[REG_FULL_LEVEL]     = 4096;
        end else begin
          vals[REG_PULSE_MIN]      = 1500;
          vals[REG_PULSE_MAX]      = 1500;
          vals[REG_PULSE_NEUTRAL]  = 4095;
          vals[REG_DEAD_BAND]      = 0;
          vals[REG_SLEW_LIMIT]     = 1;
          vals[REG_PWM_TOP]        = 1;
          vals[REG_FULL_THRESHOLD] = 0;
          vals[REG_FULL_LEVEL]     = 0;
        end
      end
    endcase
    for (int i = 0; i < $size(vals); i++) write_reg(reg_index_t'(i), CFG_W'(vals[i]));
  endtask

  task automatic offer_tick(input logic [PULSE_W-1:0] thr, input logic [PULSE_W-1:0] str,
                            input bit typed, input out_item_t want);
    in_item_t  it;
    out_item_t pred;
    bit        steady;
    it.throttle_pulse = thr;
    it.steer_pulse    = str;
    steady = (sent >= 520 && sent < 820);
    if (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 21);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pred = mix_tick(it);
    track_cmds_due.push_back(typed ? want : pred);
    sent++;
  endtask

  // receive, compare and pace the output side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (track_cmds_due.size() == 0) begin
        flag_mismatch("track command with nothing pending");
      end else begin
        head = track_cmds_due.pop_front();
        check_field("left_dir", int'(out_item.left_dir), int'(head.left_dir));
        check_field("left_level", int'(out_item.left_level), int'(head.left_level));
        check_field("right_dir", int'(out_item.right_dir), int'(head.right_dir));
        check_field("right_level", int'(out_item.right_level), int'(head.right_level));
      end
      taken++;
      if (taken == 300 || taken == 1100) hold = HOLD_CYCLES;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else if (taken >= 520 && taken < 820) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    row_t               plan[$];
    logic [PULSE_W-1:0] thr, str;
    int                 run_left;

    plan.push_back(typed_row(1500, 1500, pair_out(1, 0, 1, 0)));
    plan.push_back(typed_row(0, 1500, pair_out(1, 50, 1, 50)));
    plan.push_back(typed_row(65535, 1500, pair_out(1, 0, 1, 0)));
    plan.push_back(typed_row(65535, 0, pair_out(1, 0, 0, 50)));
    plan.push_back(typed_row(65535, 65535, pair_out(0, 50, 1, 0)));
    plan.push_back(typed_row(1519, 1481, pair_out(1, 0, 1, 0)));
    plan.push_back(tick_row(1521, 1479));
    plan.push_back(tick_row(16'h5555, 16'hAAAA));
    plan.push_back(write_row(REG_SLEW_LIMIT, 4095));
    plan.push_back(typed_row(0, 1500, pair_out(1, 1250, 1, 1250)));
    plan.push_back(typed_row(1500, 1500, pair_out(1, 0, 1, 0)));
    plan.push_back(write_row(REG_FULL_THRESHOLD, 0));
    plan.push_back(write_row(REG_FULL_LEVEL, 8191));
    plan.push_back(typed_row(0, 1500, pair_out(1, 8191, 1, 8191)));
    plan.push_back(typed_row(1500, 1500, pair_out(1, 0, 1, 0)));
    plan.push_back(write_row(REG_PWM_TOP, 4095));
    plan.push_back(write_row(REG_FULL_THRESHOLD, 4095));
    plan.push_back(typed_row(0, 1500, pair_out(1, 4095, 1, 4095)));
    plan.push_back(typed_row(65535, 1500, pair_out(1, 0, 1, 0)));
    plan.push_back(typed_row(65535, 1500, pair_out(0, 4095, 0, 4095)));
    plan.push_back(tick_row(0, 0));
    plan.push_back(write_row(REG_SLEW_LIMIT, 0));
    plan.push_back(tick_row(0, 65535));
    plan.push_back(write_row(REG_SLEW_LIMIT, 4095));
    plan.push_back(write_row(REG_PULSE_MIN, 2000));
    plan.push_back(write_row(REG_PULSE_MAX, 1000));
    plan.push_back(typed_row(0, 3000, pair_out(1, 0, 1, 0)));
    plan.push_back(write_row(REG_PULSE_MIN, 1000));
    plan.push_back(write_row(REG_PULSE_MAX, 2000));
    plan.push_back(write_row(REG_PULSE_NEUTRAL, 2100));
    plan.push_back(write_row(REG_DEAD_BAND, 255));
    plan.push_back(tick_row(2000, 1500));
    plan.push_back(write_row(REG_PULSE_NEUTRAL, 900));
    plan.push_back(tick_row(1000, 1000));
    plan.push_back(write_row(REG_PULSE_MIN, 0));
    plan.push_back(write_row(REG_PULSE_MAX, 4095));
    plan.push_back(write_row(REG_PULSE_NEUTRAL, 2048));
    plan.push_back(write_row(REG_DEAD_BAND, 0));
    plan.push_back(tick_row(0, 4095));
    plan.push_back(tick_row(4095, 2048));
    plan.push_back(tick_row(16'hFFFF, 16'h0000));

    regs_now = '{pulse_min: RST_PULSE_MIN, pulse_max: RST_PULSE_MAX,
                 pulse_neutral: RST_PULSE_NEUTRAL, dead_band: RST_DEAD_BAND,
                 slew_limit: RST_SLEW_LIMIT, pwm_top: RST_PWM_TOP,
                 full_threshold: RST_FULL_THRESHOLD, full_level: RST_FULL_LEVEL};
    left_set  = 0;
    right_set = 0;
    run_left  = 0;
    thr = '0;
    str = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        offer_tick(plan[i].thr, plan[i].str, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      load_phase(ph);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (run_left == 0) begin
          thr = pick_pulse();
          str = pick_pulse();
          run_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(2, 30)) : 1;
        end
        run_left--;
        // drain the block mid-phase
        if (ph == 2 && k == 100) settle();
        offer_tick(thr, str, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && track_cmds_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
